@@ rtl/deque_with_search_defines.svh @@
// Assertion macros used by the deque top level.
`ifndef DEQUE_WITH_SEARCH_DEFINES_SVH
`define DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dsq_pkg.sv @@
// Request codes, status codes and state type of the deque.
package dsq_pkg;

   localparam int VALUE_W = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH_FWD = 3'd4;
   localparam logic [2:0] OP_SEARCH_BWD = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_DONE   = 3'b100
   } state_type;

endpackage

@@ rtl/dsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read word when no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/deque_with_search.sv @@
// Deque top level: ring store in one RAM, front/tail pointers, search sequencer.
//
// A bounded double-ended queue of signed 32-bit values held in a ring of DEPTH RAM
// entries. One request is taken at a time; req_ready is high while no request is in
// work. A push or pop goes to S_DONE, then into the output register; S_DONE waits
// while an earlier result is not yet taken. A search reads one stored entry per
// cycle through the single RAM read port, walking from the front (code 4) or the
// back (code 5), and stops at the first match or after the last entry. Refused
// pushes (full) and pops (empty) leave the store alone and report status 2 or 1.
// Results sit in an output register, so the next request can enter while a result
// waits to be taken. The store needs no clearing after reset.
module deque_with_search #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_type,
   input  logic signed [dsq_pkg::VALUE_W-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_found,
   output logic signed [dsq_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_item_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full
);

   import dsq_pkg::*;

   `include "deque_with_search_defines.svh"

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
      if (s == IW'(DEPTH - 1)) begin
         return '0;
      end
      return s + 1'b1;
   endfunction

   function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
      if (s == '0) begin
         return IW'(DEPTH - 1);
      end
      return s - 1'b1;
   endfunction

   state_type           state_ff, state_in;
   logic [IW-1:0]       front_ff, front_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       occ_ff, occ_in;
   logic [1:0]          status_ff, status_in;
   logic                found_ff, found_in;
   logic                pop_ok_ff, pop_ok_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic                dir_back_ff, dir_back_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       left_ff, left_in;
   logic                rd_pend_ff, rd_pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_full_ff, rsp_full_in;

   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   logic [VALUE_W-1:0]  ram_rd_data;
   logic                match;
   logic                is_empty;
   logic                is_full;
   logic [IW:0]         ring_sum;
   logic [IW-1:0]       ring_chk;

   dsq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign is_empty  = (occ_ff == '0);
   assign is_full   = (occ_ff == CW'(DEPTH));
   assign match     = (ram_rd_data == key_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      pop_ok_in      = pop_ok_ff;
      key_in         = key_ff;
      dir_back_in    = dir_back_ff;
      scan_in        = scan_ff;
      left_in        = left_ff;
      rd_pend_in     = rd_pend_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_full_in    = rsp_full_ff;
      wr_en          = 1'b0;
      wr_addr        = front_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               found_in  = 1'b0;
               pop_ok_in = 1'b0;
               key_in    = req_value;
               state_in  = S_DONE;
               unique case (req_type) inside
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_dec(front_ff);
                        front_in = slot_dec(front_ff);
                        occ_in   = occ_ff + 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = tail_ff;
                        tail_in = slot_inc(tail_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = front_ff;
                        front_in  = slot_inc(front_ff);
                        occ_in    = occ_ff - 1'b1;
                        pop_ok_in = 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = slot_dec(tail_ff);
                        tail_in   = slot_dec(tail_ff);
                        occ_in    = occ_ff - 1'b1;
                        pop_ok_in = 1'b1;
                     end
                  end
                  OP_SEARCH_FWD, OP_SEARCH_BWD: begin
                     // an empty queue answers not found at once
                     if (!is_empty) begin
                        state_in    = S_SEARCH;
                        dir_back_in = (req_type == OP_SEARCH_BWD);
                        scan_in     = (req_type == OP_SEARCH_BWD) ? slot_dec(tail_ff)
                                                                  : front_ff;
                        left_in     = occ_ff;
                        rd_pend_in  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // compare the word read last cycle; stop at a hit or after the last entry
            if (rd_pend_ff && (match || left_ff == '0)) begin
               found_in   = match;
               rd_pend_in = 1'b0;
               state_in   = S_DONE;
            end else if (left_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff;
               scan_in    = dir_back_ff ? slot_dec(scan_ff) : slot_inc(scan_ff);
               left_in    = left_ff - 1'b1;
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
         end
         S_DONE: begin
            // pop data stays in the RAM read register until the next read
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_found_in   = found_ff;
               rsp_removed_in = pop_ok_ff ? ram_rd_data : '0;
               rsp_count_in   = occ_ff;
               rsp_empty_in   = is_empty;
               rsp_full_in    = is_full;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      found_ff       <= found_in;
      pop_ok_ff      <= pop_ok_in;
      key_ff         <= key_in;
      dir_back_ff    <= dir_back_in;
      scan_ff        <= scan_in;
      left_ff        <= left_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_item_count    = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;

   // tail must always sit occupancy slots past front, modulo the ring size
   assign ring_sum = (IW+1)'(front_ff) + (IW+1)'(occ_ff);
   assign ring_chk = (ring_sum >= (IW+1)'(DEPTH)) ? IW'(ring_sum - (IW+1)'(DEPTH))
                                                  : ring_sum[IW-1:0];

   `DSQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_ff <= CW'(DEPTH), "occupancy above DEPTH")
   `DSQ_ASSERT_NOW(a_ring_consistent, 1'b1, tail_ff == ring_chk, "tail and front disagree")
   `DSQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
                    "second request taken while one is in work")
   `DSQ_ASSERT_NOW(a_no_found_empty, state_ff == S_DONE && is_empty, !found_ff,
                   "search on empty queue reported found")

endmodule
